@@ rtl/cks_pkg.sv @@
// ----------------------------------------------------------------------------
// cks_pkg: shared types and constants for the two-key index sorter
// Record layout, cell control group, sequencer states and key compare.
// ----------------------------------------------------------------------------
package cks_pkg;

    localparam int MAX_RECORDS = 64;
    localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
    localparam int CPU_W       = 16;
    localparam int PID_W       = 32;
    localparam int POS_W       = 6;

    typedef struct packed {
        logic [CPU_W-1:0] cpu;
        logic [PID_W-1:0] pid;
        logic [POS_W-1:0] pos;
    } rec_t;

    typedef struct packed {
        logic insert;
        logic drain;
    } cell_ctl_t;

    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } state_t;

    // true when key a is strictly greater than key b
    function automatic logic key_greater(input rec_t a, input rec_t b);
        logic res;
        if (a.cpu != b.cpu)
        begin
            res = (a.cpu > b.cpu);
        end
        else
        begin
            res = (a.pid > b.pid);
        end
        return res;
    endfunction

endpackage

@@ rtl/cks_cell.sv @@
// ----------------------------------------------------------------------------
// cks_cell: one slot of the insertion chain
// Holds one record; takes the new record, shifts up, or shifts down on drain.
// ----------------------------------------------------------------------------
module cks_cell (
    input  logic              clk,
    input  cks_pkg::cell_ctl_t ctl,
    input  logic              occupied,
    input  cks_pkg::rec_t     ins_rec,
    input  cks_pkg::rec_t     prev_rec,
    input  logic              prev_gt,
    input  cks_pkg::rec_t     next_rec,
    output cks_pkg::rec_t     cur_rec,
    output logic              gt
);
    import cks_pkg::*;

    rec_t rec_reg;
    rec_t rec_next;

    // an empty slot counts as greater than any key
    assign gt      = !occupied || key_greater(rec_reg, ins_rec);
    assign cur_rec = rec_reg;

    always_comb
    begin
        rec_next = rec_reg;
        if (ctl.drain)
        begin
            rec_next = next_rec;
        end
        else if (ctl.insert && gt)
        begin
            rec_next = prev_gt ? prev_rec : ins_rec;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

endmodule

@@ rtl/composite_key_index_sort_top.sv @@
// ----------------------------------------------------------------------------
// composite_key_index_sort_top: sort records by (cpu id, particle id)
// Insertion chain of cells that keeps the list sorted while it loads.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one record per transfer, cpu_id,
//   particle_id and last_item. A record is placed into the sorted chain in
//   the cycle of its transfer, so loading runs at one record per cycle.
//   Records beyond MAX_RECORDS are dropped; a dropped last record still
//   starts the output run.
//   Output channel (out_valid/out_ready): after the transfer of a record
//   marked last, the held records leave in ascending key order, one per
//   cycle while out_ready is high, starting the cycle after that transfer.
//   Equal keys come out in load order. Each carries its load position; the
//   final one has last_result set. While the run drains, in_ready is low;
//   it rises the cycle after the final result transfers. Loading and output
//   do not overlap: the single shift chain either inserts or drains, never
//   both at once. A stalled receiver simply holds the head record on the
//   outputs. Reset empties the chain (record count to zero) and returns to
//   loading.
// ----------------------------------------------------------------------------
module composite_key_index_sort_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [cks_pkg::CPU_W-1:0]  cpu_id,
    input  logic [cks_pkg::PID_W-1:0]  particle_id,
    input  logic                       last_item,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [cks_pkg::POS_W-1:0]  original_position,
    output logic [cks_pkg::CPU_W-1:0]  out_cpu_id,
    output logic [cks_pkg::PID_W-1:0]  out_particle_id,
    output logic                       last_result
);
    import cks_pkg::*;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    cell_ctl_t        ctl;
    rec_t             ins_rec;
    logic             in_xfer;
    logic             out_xfer;

    rec_t             cell_rec [MAX_RECORDS];
    logic             cell_gt  [MAX_RECORDS];

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;

    // new record tagged with its load position
    assign ins_rec.cpu = cpu_id;
    assign ins_rec.pid = particle_id;
    assign ins_rec.pos = POS_W'(count_reg);

    // sequencer: load until the last record, then drain the chain
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ctl        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_xfer)
                begin
                    // drop the record when the chain is full
                    if (count_reg < CNT_W'(MAX_RECORDS))
                    begin
                        ctl.insert = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (last_item)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                out_valid = 1'b1;
                if (out_xfer)
                begin
                    ctl.drain  = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                    if (count_reg == CNT_W'(1))
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // chain of cells, slot 0 holds the smallest key
    for (genvar i = 0; i < MAX_RECORDS; i++)
    begin : g_cell
        localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
        logic occ;
        logic prev_gt;
        rec_t prev_rec;
        rec_t next_rec;

        assign occ = (IDX < count_reg);

        if (i == 0)
        begin : g_head
            assign prev_gt  = 1'b0;
            assign prev_rec = ins_rec;
        end
        else
        begin : g_body
            assign prev_gt  = cell_gt[i-1];
            assign prev_rec = cell_rec[i-1];
        end

        if (i == MAX_RECORDS - 1)
        begin : g_tail
            assign next_rec = cell_rec[i];
        end
        else
        begin : g_mid
            assign next_rec = cell_rec[i+1];
        end

        cks_cell u_cell (
            .clk      (clk),
            .ctl      (ctl),
            .occupied (occ),
            .ins_rec  (ins_rec),
            .prev_rec (prev_rec),
            .prev_gt  (prev_gt),
            .next_rec (next_rec),
            .cur_rec  (cell_rec[i]),
            .gt       (cell_gt[i])
        );
    end

    // head of the chain drives the result
    assign original_position = cell_rec[0].pos;
    assign out_cpu_id        = cell_rec[0].cpu;
    assign out_particle_id   = cell_rec[0].pid;
    assign last_result       = (count_reg == CNT_W'(1));

`ifndef NO_ASSERTIONS
    a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (count_reg != '0))
        else $error("drain with empty chain");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_RECORDS))
        else $error("record count beyond capacity");

    a_final_returns: assert property (@(posedge clk) disable iff (!rst_n)
        (out_xfer && last_result) |=> (in_ready && (count_reg == '0)))
        else $error("chain not empty after final result");

    a_last_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && last_item) |=> out_valid)
        else $error("last record did not start output run");
`endif

endmodule
